>>> rtl/icv_pkg.sv
// shared types and constants for the int8 kernel image convolution block
`default_nettype none

package icv_pkg;

    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int ROW_W       = 13;
    localparam int RESULT_W    = 16;
    localparam int COEF_COUNT  = 25;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0]  MASK_SIZE_RST    = 3'd3;
    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef enum logic [2:0] {
        REG_MASK_SIZE    = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_COEF_LOW     = 3'd3,
        REG_COEF_MID     = 3'd4,
        REG_COEF_HIGH    = 3'd5,
        REG_COEF_FINAL   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  mask;
        logic [10:0] width;
        logic [11:0] height;
    } t_geom;

endpackage

`default_nettype wire

>>> rtl/icv_ram.sv
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module icv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/icv_front.sv
// front end: raster counters, line stores, window register and result classification
`default_nettype none

module icv_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_MASK  = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  icv_pkg::t_geom                    i_geom,
    input  logic                              i_s_valid,
    output logic                              o_s_ready,
    input  logic [7:0]                        i_pixel,
    input  logic                              i_room,
    output logic                              o_push,
    output logic [8*MAX_MASK*MAX_MASK-1:0]    o_push_window,
    output logic                              o_push_last
);

    import icv_pkg::*;

    localparam int NumLines = MAX_MASK - 1;
    localparam int LineLen  = MAX_WIDTH + MAX_MASK - 1;
    localparam int AddrW    = $clog2(LineLen);
    localparam int PosW     = (AddrW > 12) ? AddrW + 1 : 13;
    localparam int LinesW   = ((NumLines > 0) ? NumLines : 1) * 8;

    logic [AddrW-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;
    logic [PosW-1:0]  col_x, row_x, mm1, pad2, pw, ph, wid, hgt, x, y;
    logic             emit, last;

    logic             r_a_valid;
    logic             r_a_emit;
    logic             r_a_last;
    logic [7:0]       r_a_px;

    logic [7:0]       r_win [MAX_MASK][MAX_MASK];
    logic [7:0]       n_win [MAX_MASK][MAX_MASK];
    logic [7:0]       column [MAX_MASK];
    logic [LinesW-1:0] line_q;

    assign accept    = i_s_valid && i_room;
    assign o_s_ready = i_room;

    always_comb begin
        mm1   = PosW'(i_geom.mask) - PosW'(1);
        pad2  = PosW'(i_geom.mask[2:1]) << 1;
        wid   = PosW'(i_geom.width);
        hgt   = PosW'(i_geom.height);
        pw    = wid + pad2;
        ph    = hgt + pad2;
        col_x = PosW'(r_col);
        row_x = PosW'(r_row);
        x     = col_x - mm1;
        y     = row_x - mm1;
        emit  = (row_x >= mm1) && (col_x >= mm1) && (x < wid) && (y < hgt);
        last  = (x == wid - PosW'(1)) && (y == hgt - PosW'(1));
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_x + PosW'(1) >= pw) begin
                n_col = '0;
                if (row_x + PosW'(1) >= ph) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + AddrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px   <= i_pixel;
            r_a_emit <= emit;
            r_a_last <= last;
        end
    end

    // line stores hold the previous rows of each column, oldest in the low byte
    generate
        if (NumLines > 0) begin : g_lines
            logic [AddrW-1:0]  r_a_col;
            logic              r_fwd_valid;
            logic [AddrW-1:0]  r_fwd_addr;
            logic [LinesW-1:0] r_fwd_data;
            logic [LinesW-1:0] ram_q;
            logic [LinesW+7:0] shifted;

            always_ff @(posedge i_clk) begin
                if (accept) begin
                    r_a_col <= r_col;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_fwd_valid <= 1'b0;
                end else if (r_a_valid) begin
                    r_fwd_valid <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_a_valid) begin
                    r_fwd_addr <= r_a_col;
                    r_fwd_data <= shifted[LinesW+7:8];
                end
            end

            // bypass a write that landed on the same column as the read
            assign line_q  = (r_fwd_valid && (r_fwd_addr == r_a_col)) ? r_fwd_data : ram_q;
            assign shifted = {r_a_px, line_q};

            icv_ram #(
                .WIDTH (LinesW),
                .DEPTH (LineLen)
            ) u_lines (
                .i_clk   (i_clk),
                .i_we    (r_a_valid),
                .i_waddr (r_a_col),
                .i_wdata (shifted[LinesW+7:8]),
                .i_re    (accept),
                .i_raddr (r_col),
                .o_rdata (ram_q)
            );
        end else begin : g_no_lines
            assign line_q = '0;
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < NumLines; i++) begin
            column[i] = line_q[8*i +: 8];
        end
        column[MAX_MASK-1] = r_a_px;
        for (int i = 0; i < MAX_MASK; i++) begin
            for (int j = 0; j < MAX_MASK - 1; j++) begin
                n_win[i][j] = r_win[i][j+1];
            end
            n_win[i][MAX_MASK-1] = column[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_MASK; i++) begin
            for (int j = 0; j < MAX_MASK; j++) begin
                o_push_window[8*(i*MAX_MASK+j) +: 8] = n_win[i][j];
            end
        end
    end

    assign o_push      = r_a_valid && r_a_emit;
    assign o_push_last = r_a_last;

endmodule

`default_nettype wire

>>> rtl/icv_queue.sv
// short fifo of windows between front end and multiply-add back end
`default_nettype none

module icv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_pop;

    assign do_pop  = i_pop && o_valid;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // two free slots: one for the item in the front stage, one for a new beat
    assign o_room  = (r_count <= CntW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icv_back.sv
// back end: coefficient placement, parallel products, row sums and output register
`default_nettype none

module icv_back #(
    parameter int MAX_MASK = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_pop,
    input  logic [8*MAX_MASK*MAX_MASK-1:0]        i_window,
    input  logic                                  i_last,
    input  logic [2:0]                            i_mask,
    input  logic [8*icv_pkg::COEF_COUNT-1:0]      i_coefs,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [icv_pkg::RESULT_W-1:0]          o_data,
    output logic                                  o_last
);

    import icv_pkg::*;

    logic signed [7:0]    r_pos_coef [MAX_MASK][MAX_MASK];
    logic signed [16:0]   prod_c     [MAX_MASK][MAX_MASK];
    logic [RESULT_W-1:0]  r_prod     [MAX_MASK][MAX_MASK];
    logic [RESULT_W-1:0]  rsum_c     [MAX_MASK];
    logic [RESULT_W-1:0]  r_rsum     [MAX_MASK];
    logic [RESULT_W-1:0]  total_c;
    logic                 en;
    logic                 r_p_valid, r_p_last;
    logic                 r_s_valid, r_s_last;
    logic                 r_o_valid, r_o_last;
    logic [RESULT_W-1:0]  r_o_data;

    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && i_valid;

    // the kernel sits in the bottom right corner of the window
    always_ff @(posedge i_clk) begin : p_coef_map
        int base;
        int k;
        base = MAX_MASK - int'(i_mask);
        for (int pi = 0; pi < MAX_MASK; pi++) begin
            for (int pj = 0; pj < MAX_MASK; pj++) begin
                if (pi >= base && pj >= base) begin
                    k = (pi - base) * int'(i_mask) + (pj - base);
                    r_pos_coef[pi][pj] <= i_coefs[8*k +: 8];
                end else begin
                    r_pos_coef[pi][pj] <= '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_MASK; i++) begin
            for (int j = 0; j < MAX_MASK; j++) begin
                prod_c[i][j] = r_pos_coef[i][j] *
                               $signed({1'b0, i_window[8*(i*MAX_MASK+j) +: 8]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_MASK; i++) begin
            rsum_c[i] = '0;
            for (int j = 0; j < MAX_MASK; j++) begin
                rsum_c[i] = rsum_c[i] + r_prod[i][j];
            end
        end
        total_c = '0;
        for (int i = 0; i < MAX_MASK; i++) begin
            total_c = total_c + r_rsum[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < MAX_MASK; i++) begin
                for (int j = 0; j < MAX_MASK; j++) begin
                    r_prod[i][j] <= prod_c[i][j][RESULT_W-1:0];
                end
            end
            r_rsum   <= rsum_c;
            r_o_data <= total_c;
            r_p_last <= i_last;
            r_s_last <= r_p_last;
            r_o_last <= r_s_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

>>> rtl/int8_kernel_image_convolution.sv
// top level: register port, front end, window queue and multiply-add back end
//
// 2d valid convolution of a padded 8-bit raster stream with a signed 8-bit
// kernel of side mask_size (1 to MAX_MASK), 16-bit wrapping result.
// s_* beats carry one padded pixel each, rows of image_width + 2*(mask/2)
// pixels, frames of image_height + 2*(mask/2) rows. m_* beats carry one
// result per valid window position; m_tlast marks the last result of a frame.
// registers are 64-bit apb words at byte address 8*index: mask_size,
// image_width, image_height, three packed coefficient words, coef_final.
// the user must write registers only while the stream is idle; it goes unchecked.
// throughput is one pixel per cycle while s_tready is high; the line stores
// are one ram read and one write per pixel at the same column, with a
// bypass for back to back reuse of a column.
// a pixel beat passes the ram read, the queue (written with the window
// update), the product, row-sum and output registers to its result beat.
// when m_tready is low the back end holds and the 4-deep window queue keeps
// taking pixels until fewer than two slots are free, then s_tready drops.
// reset clears counters, queue and valids; line stores are not cleared.
`default_nettype none

module int8_kernel_image_convolution #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_MASK  = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] conv_value
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [icv_pkg::PADDR_W-1:0]  paddr,
    input  logic [icv_pkg::PDATA_W-1:0]  pwdata,
    output logic [icv_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    import icv_pkg::*;

    localparam int WinW = 8 * MAX_MASK * MAX_MASK;

    logic [2:0]  r_mask_size;
    logic [10:0] r_image_width;
    logic [11:0] r_image_height;
    logic [63:0] r_coef_low, r_coef_mid, r_coef_high;
    logic [7:0]  r_coef_final;

    logic        wr;
    t_reg_idx    reg_idx;
    t_geom       geom;

    logic            push, push_last, room;
    logic [WinW-1:0] push_window;
    logic [WinW:0]   q_data;
    logic            q_valid, q_pop;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_size    <= MASK_SIZE_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_coef_low     <= '0;
            r_coef_mid     <= '0;
            r_coef_high    <= '0;
            r_coef_final   <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_MASK_SIZE:    r_mask_size    <= pwdata[2:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[11:0];
                REG_COEF_LOW:     r_coef_low     <= pwdata;
                REG_COEF_MID:     r_coef_mid     <= pwdata;
                REG_COEF_HIGH:    r_coef_high    <= pwdata;
                REG_COEF_FINAL:   r_coef_final   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MASK_SIZE:    prdata = PDATA_W'(r_mask_size);
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(r_image_height);
            REG_COEF_LOW:     prdata = r_coef_low;
            REG_COEF_MID:     prdata = r_coef_mid;
            REG_COEF_HIGH:    prdata = r_coef_high;
            REG_COEF_FINAL:   prdata = PDATA_W'(r_coef_final);
            default:          prdata = '0;
        endcase
    end

    // out-of-range settings saturate
    always_comb begin
        if (r_mask_size == 3'd0) begin
            geom.mask = 3'd1;
        end else if (int'(r_mask_size) > MAX_MASK) begin
            geom.mask = 3'(MAX_MASK);
        end else begin
            geom.mask = r_mask_size;
        end
        if (r_image_width == 11'd0) begin
            geom.width = 11'd1;
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            geom.width = 11'(MAX_WIDTH);
        end else begin
            geom.width = r_image_width;
        end
        geom.height = (r_image_height == 12'd0) ? 12'd1 : r_image_height;
    end

    icv_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_MASK  (MAX_MASK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_s_valid     (s_tvalid),
        .o_s_ready     (s_tready),
        .i_pixel       (s_tdata),
        .i_room        (room),
        .o_push        (push),
        .o_push_window (push_window),
        .o_push_last   (push_last)
    );

    icv_queue #(
        .WIDTH (WinW + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_last, push_window}),
        .o_room      (room),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    icv_back #(
        .MAX_MASK (MAX_MASK)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_window (q_data[WinW-1:0]),
        .i_last   (q_data[WinW]),
        .i_mask   (geom.mask),
        .i_coefs  ({r_coef_final, r_coef_high, r_coef_mid, r_coef_low}),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_data   (m_tdata),
        .o_last   (m_tlast)
    );

endmodule

`default_nettype wire
